>>> sv/grma_pkg.sv
package grma_pkg;

    // Field widths of the input and result words.
    localparam int RAW_W   = 16;
    localparam int RATE_W  = 17;
    localparam int TEMP_W  = 15;
    localparam int SPEED_W = 17;
    localparam int PCT_W   = 7;

    // Three rate lanes plus one auxiliary lane (temperature, then the window average).
    localparam int AXES     = 3;
    localparam int LANES    = 4;
    localparam int AUX_LANE = 3;

    // Box filter depth and the widths that follow from it.
    localparam int WINDOW_LENGTH = 6;
    localparam int SLOT_W        = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int SUM_W         = SPEED_W + SLOT_W;

    // Bit-serial restoring divider: one quotient bit per cycle.
    localparam int QUO_W = 17;
    localparam int DVD_W = 2 * QUO_W;
    localparam int DVS_W = 16;
    localparam int CNT_W = $clog2(QUO_W);

    // Bit-serial square root: one root bit (two radicand bits) per cycle.
    localparam int ROOT_W = 17;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;
    localparam int TRY_W  = REM_W + 2;
    localparam int SQ_W   = 32;

    // Scaling constants.
    localparam int RATE_MUL     = 100000;
    localparam int RATE_DIV     = 65535;
    localparam int TEMP_MUL     = 10000;
    localparam int TEMP_DIV     = 33387;
    localparam int TEMP_OFFSET  = 2100;
    localparam int PERCENT_FULL = 100;

    // Ranges of the result fields.
    localparam int RATE_LIMIT = 50000;
    localparam int TEMP_LOW   = -7714;
    localparam int TEMP_HIGH  = 11914;
    localparam int SPEED_MAX  = 86603;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_LOAD   = 9'b000000010,
        ST_DIV    = 9'b000000100,
        ST_POST   = 9'b000001000,
        ST_SQUARE = 9'b000010000,
        ST_SUM    = 9'b000100000,
        ST_ROOT   = 9'b001000000,
        ST_WIN    = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    typedef enum logic [3:0] {
        PH_SCALE = 4'b0001,
        PH_OLD   = 4'b0010,
        PH_NEW   = 4'b0100,
        PH_AVG   = 4'b1000
    } phase_t;

    function automatic logic [RATE_W-1:0] magnitude(input logic signed [RATE_W-1:0] v);
        return v[RATE_W-1] ? RATE_W'(-v) : RATE_W'(v);
    endfunction

    function automatic logic signed [RATE_W-1:0] apply_sign(input logic neg,
                                                            input logic [QUO_W-1:0] q);
        logic signed [RATE_W-1:0] s;
        s = RATE_W'(q);
        return neg ? -s : s;
    endfunction

endpackage

>>> sv/gyro_rate_magnitude_averager.sv
// Gyro rate magnitude averager.
//
// The input channel (in_valid / in_stall) carries one word per gyro sample set: three
// raw signed rates and a raw die temperature. A word is taken at a rising edge where
// in_valid is high and in_stall is low. The output channel (out_valid / out_stall)
// returns one word per input word: the three smoothed rates, the temperature in
// Celsius times 100, and the box-filtered magnitude of the rate vector.
// The configuration channel (cfg_valid / cfg_ready) writes smoothing_percent; it is
// always ready and should only be written while no sample is in flight.
//
// Each sample runs through a sequencer. Four bit-serial dividers (one per axis, one
// auxiliary) work side by side for three passes of load, 17 steps and unload:
// scaling, then the two halves of the smoothing filter. Squaring, summing, a 17-step
// square root and the window update follow, and a last pass divides the window sum.
// The block takes no new sample until the last one has reached the output register.
// The result sits in an output register, so the next sample is taken while it waits;
// if the receiver holds out_stall, the block finishes that next sample and then
// waits with in_stall high until the output register frees up.
// Reset clears the filter states, the magnitude history, the window sum and the
// smoothing register, and leaves the block idle with no result pending.
module gyro_rate_magnitude_averager (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic signed [grma_pkg::RAW_W-1:0]          raw_rate_x,
    input  logic signed [grma_pkg::RAW_W-1:0]          raw_rate_y,
    input  logic signed [grma_pkg::RAW_W-1:0]          raw_rate_z,
    input  logic signed [grma_pkg::RAW_W-1:0]          raw_temperature,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [grma_pkg::RATE_W-1:0]         roll_rate,
    output logic signed [grma_pkg::RATE_W-1:0]         pitch_rate,
    output logic signed [grma_pkg::RATE_W-1:0]         yaw_rate,
    output logic signed [grma_pkg::TEMP_W-1:0]         temperature,
    output logic        [grma_pkg::SPEED_W-1:0]        average_speed,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic        [grma_pkg::PCT_W-1:0]          smoothing_percent
);

    // Control state.
    grma_pkg::state_t                  state_reg, state_next;
    grma_pkg::phase_t                  phase_reg, phase_next;
    logic [grma_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              out_valid_reg, out_valid_next;
    logic [grma_pkg::PCT_W-1:0]        pct_reg;

    // Filter state as seen by the model.
    logic signed [grma_pkg::RATE_W-1:0] rate_reg [grma_pkg::AXES];
    logic signed [grma_pkg::RATE_W-1:0] rate_next [grma_pkg::AXES];
    logic [grma_pkg::SPEED_W-1:0]       hist_reg [grma_pkg::WINDOW_LENGTH];
    logic [grma_pkg::SPEED_W-1:0]       hist_next [grma_pkg::WINDOW_LENGTH];
    logic [grma_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic [grma_pkg::SUM_W-1:0]         wsum_reg, wsum_next;

    // Working registers of one sample.
    logic signed [grma_pkg::RAW_W-1:0]  raw_reg [grma_pkg::AXES];
    logic signed [grma_pkg::RAW_W-1:0]  raw_temp_reg;
    logic signed [grma_pkg::RATE_W-1:0] scaled_reg [grma_pkg::AXES];
    logic signed [grma_pkg::RATE_W-1:0] scaled_next [grma_pkg::AXES];
    logic signed [grma_pkg::RATE_W-1:0] part_reg [grma_pkg::AXES];
    logic signed [grma_pkg::RATE_W-1:0] part_next [grma_pkg::AXES];
    logic signed [grma_pkg::TEMP_W-1:0] temp_reg, temp_next;
    logic [grma_pkg::SQ_W-1:0]          sq_reg [grma_pkg::AXES];
    logic [grma_pkg::SQ_W-1:0]          sq_next [grma_pkg::AXES];

    // Divider lanes: remainder, dividend/quotient shift register, divisor.
    logic [grma_pkg::DVS_W-1:0]         div_rem_reg [grma_pkg::LANES];
    logic [grma_pkg::DVS_W-1:0]         div_rem_next [grma_pkg::LANES];
    logic [grma_pkg::QUO_W-1:0]         div_lo_reg [grma_pkg::LANES];
    logic [grma_pkg::QUO_W-1:0]         div_lo_next [grma_pkg::LANES];
    logic [grma_pkg::DVS_W-1:0]         div_dv_reg [grma_pkg::LANES];
    logic [grma_pkg::DVS_W-1:0]         div_dv_next [grma_pkg::LANES];

    // Square root: radicand shift register, partial remainder, partial root.
    logic [grma_pkg::RAD_W-1:0]         rad_reg, rad_next;
    logic [grma_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [grma_pkg::ROOT_W-1:0]        root_reg, root_next;

    // Output register.
    logic signed [grma_pkg::RATE_W-1:0] out_rate_reg [grma_pkg::AXES];
    logic signed [grma_pkg::RATE_W-1:0] out_rate_next [grma_pkg::AXES];
    logic signed [grma_pkg::TEMP_W-1:0] out_temp_reg, out_temp_next;
    logic [grma_pkg::SPEED_W-1:0]       out_speed_reg, out_speed_next;

    // Combinational helpers.
    logic                               in_take;
    logic [grma_pkg::PCT_W-1:0]         pct_keep;
    logic [grma_pkg::PCT_W-1:0]         pct_take;
    logic [grma_pkg::DVD_W-1:0]         ld_num [grma_pkg::LANES];
    logic [grma_pkg::DVS_W-1:0]         ld_dv [grma_pkg::LANES];
    logic [grma_pkg::DVS_W:0]           div_try [grma_pkg::LANES];
    logic                               div_ge [grma_pkg::LANES];
    logic [grma_pkg::TRY_W-1:0]         sqrt_try;
    logic [grma_pkg::TRY_W-1:0]         sqrt_sub;
    logic                               sqrt_ge;
    logic signed [grma_pkg::TEMP_W:0]   temp_q;
    logic signed [grma_pkg::TEMP_W:0]   temp_val;

    assign in_stall  = (state_reg != grma_pkg::ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid     = out_valid_reg;
    assign roll_rate     = out_rate_reg[0];
    assign pitch_rate    = out_rate_reg[1];
    assign yaw_rate      = out_rate_reg[2];
    assign temperature   = out_temp_reg;
    assign average_speed = out_speed_reg;

    // A register value above one hundred percent behaves as one hundred.
    assign pct_keep = (pct_reg > grma_pkg::PCT_W'(grma_pkg::PERCENT_FULL))
                    ? grma_pkg::PCT_W'(grma_pkg::PERCENT_FULL) : pct_reg;
    assign pct_take = grma_pkg::PCT_W'(grma_pkg::PERCENT_FULL) - pct_keep;

    // Operands loaded into the divider lanes at the start of each pass.
    always_comb
    begin
        for (int i = 0; i < grma_pkg::LANES; i++)
        begin
            ld_num[i] = '0;
            ld_dv[i]  = grma_pkg::DVS_W'(grma_pkg::PERCENT_FULL);
        end
        case (phase_reg)
            grma_pkg::PH_SCALE:
            begin
                for (int i = 0; i < grma_pkg::AXES; i++)
                begin
                    ld_num[i] = grma_pkg::DVD_W'(grma_pkg::magnitude(
                                    grma_pkg::RATE_W'(raw_reg[i])))
                              * grma_pkg::DVD_W'(grma_pkg::RATE_MUL);
                    ld_dv[i]  = grma_pkg::DVS_W'(grma_pkg::RATE_DIV);
                end
                ld_num[grma_pkg::AUX_LANE] = grma_pkg::DVD_W'(grma_pkg::magnitude(
                                                 grma_pkg::RATE_W'(raw_temp_reg)))
                                           * grma_pkg::DVD_W'(grma_pkg::TEMP_MUL);
                ld_dv[grma_pkg::AUX_LANE]  = grma_pkg::DVS_W'(grma_pkg::TEMP_DIV);
            end
            grma_pkg::PH_OLD:
            begin
                for (int i = 0; i < grma_pkg::AXES; i++)
                begin
                    ld_num[i] = grma_pkg::DVD_W'(grma_pkg::magnitude(rate_reg[i]))
                              * grma_pkg::DVD_W'(pct_keep);
                end
            end
            grma_pkg::PH_NEW:
            begin
                for (int i = 0; i < grma_pkg::AXES; i++)
                begin
                    ld_num[i] = grma_pkg::DVD_W'(grma_pkg::magnitude(scaled_reg[i]))
                              * grma_pkg::DVD_W'(pct_take);
                end
            end
            grma_pkg::PH_AVG:
            begin
                ld_num[grma_pkg::AUX_LANE] = grma_pkg::DVD_W'(wsum_reg);
                ld_dv[grma_pkg::AUX_LANE]  = grma_pkg::DVS_W'(grma_pkg::WINDOW_LENGTH);
            end
            default:
            begin
            end
        endcase
    end

    // One restoring division step per lane.
    always_comb
    begin
        for (int i = 0; i < grma_pkg::LANES; i++)
        begin
            div_try[i] = {div_rem_reg[i], div_lo_reg[i][grma_pkg::QUO_W-1]};
            div_ge[i]  = (div_try[i] >= {1'b0, div_dv_reg[i]});
        end
    end

    // One square root step: bring down two radicand bits, try 4*root+1.
    assign sqrt_try = {rem_reg, rad_reg[grma_pkg::RAD_W-1 -: 2]};
    assign sqrt_sub = {1'b0, root_reg, 2'b01};
    assign sqrt_ge  = (sqrt_try >= sqrt_sub);

    // Temperature from the auxiliary lane's quotient.
    assign temp_q   = (grma_pkg::TEMP_W+1)'(div_lo_reg[grma_pkg::AUX_LANE]);
    assign temp_val = (raw_temp_reg[grma_pkg::RAW_W-1] ? -temp_q : temp_q)
                    + (grma_pkg::TEMP_W+1)'(grma_pkg::TEMP_OFFSET);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        rate_next      = rate_reg;
        hist_next      = hist_reg;
        slot_next      = slot_reg;
        wsum_next      = wsum_reg;
        scaled_next    = scaled_reg;
        part_next      = part_reg;
        temp_next      = temp_reg;
        sq_next        = sq_reg;
        div_rem_next   = div_rem_reg;
        div_lo_next    = div_lo_reg;
        div_dv_next    = div_dv_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        out_rate_next  = out_rate_reg;
        out_temp_next  = out_temp_reg;
        out_speed_next = out_speed_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            grma_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    phase_next = grma_pkg::PH_SCALE;
                    state_next = grma_pkg::ST_LOAD;
                end
            end
            grma_pkg::ST_LOAD:
            begin
                // The dividend is below divisor * 2^QUO_W, so its upper half fits the remainder.
                for (int i = 0; i < grma_pkg::LANES; i++)
                begin
                    div_rem_next[i] = ld_num[i][grma_pkg::QUO_W +: grma_pkg::DVS_W];
                    div_lo_next[i]  = ld_num[i][grma_pkg::QUO_W-1:0];
                    div_dv_next[i]  = ld_dv[i];
                end
                cnt_next   = '0;
                state_next = grma_pkg::ST_DIV;
            end
            grma_pkg::ST_DIV:
            begin
                for (int i = 0; i < grma_pkg::LANES; i++)
                begin
                    div_rem_next[i] = div_ge[i]
                                    ? grma_pkg::DVS_W'(div_try[i] - {1'b0, div_dv_reg[i]})
                                    : div_try[i][grma_pkg::DVS_W-1:0];
                    div_lo_next[i]  = {div_lo_reg[i][grma_pkg::QUO_W-2:0], div_ge[i]};
                end
                if (cnt_reg == grma_pkg::CNT_W'(grma_pkg::QUO_W - 1))
                begin
                    state_next = grma_pkg::ST_POST;
                end
                else
                begin
                    cnt_next = grma_pkg::CNT_W'(cnt_reg + 1'b1);
                end
            end
            grma_pkg::ST_POST:
            begin
                case (phase_reg)
                    grma_pkg::PH_SCALE:
                    begin
                        for (int i = 0; i < grma_pkg::AXES; i++)
                        begin
                            scaled_next[i] = grma_pkg::apply_sign(
                                                 raw_reg[i][grma_pkg::RAW_W-1], div_lo_reg[i]);
                        end
                        temp_next  = temp_val[grma_pkg::TEMP_W-1:0];
                        phase_next = grma_pkg::PH_OLD;
                        state_next = grma_pkg::ST_LOAD;
                    end
                    grma_pkg::PH_OLD:
                    begin
                        for (int i = 0; i < grma_pkg::AXES; i++)
                        begin
                            part_next[i] = grma_pkg::apply_sign(
                                               rate_reg[i][grma_pkg::RATE_W-1], div_lo_reg[i]);
                        end
                        phase_next = grma_pkg::PH_NEW;
                        state_next = grma_pkg::ST_LOAD;
                    end
                    grma_pkg::PH_NEW:
                    begin
                        for (int i = 0; i < grma_pkg::AXES; i++)
                        begin
                            rate_next[i] = part_reg[i] + grma_pkg::apply_sign(
                                               scaled_reg[i][grma_pkg::RATE_W-1], div_lo_reg[i]);
                        end
                        state_next = grma_pkg::ST_SQUARE;
                    end
                    grma_pkg::PH_AVG:
                    begin
                        state_next = grma_pkg::ST_DONE;
                    end
                    default:
                    begin
                        state_next = grma_pkg::ST_IDLE;
                    end
                endcase
            end
            grma_pkg::ST_SQUARE:
            begin
                for (int i = 0; i < grma_pkg::AXES; i++)
                begin
                    sq_next[i] = grma_pkg::SQ_W'(
                                     grma_pkg::RAD_W'(grma_pkg::magnitude(rate_reg[i]))
                                   * grma_pkg::RAD_W'(grma_pkg::magnitude(rate_reg[i])));
                end
                state_next = grma_pkg::ST_SUM;
            end
            grma_pkg::ST_SUM:
            begin
                rad_next   = grma_pkg::RAD_W'(sq_reg[0]) + grma_pkg::RAD_W'(sq_reg[1])
                           + grma_pkg::RAD_W'(sq_reg[2]);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = grma_pkg::ST_ROOT;
            end
            grma_pkg::ST_ROOT:
            begin
                rem_next  = sqrt_ge ? grma_pkg::REM_W'(sqrt_try - sqrt_sub)
                                    : sqrt_try[grma_pkg::REM_W-1:0];
                root_next = {root_reg[grma_pkg::ROOT_W-2:0], sqrt_ge};
                rad_next  = {rad_reg[grma_pkg::RAD_W-3:0], 2'b00};
                if (cnt_reg == grma_pkg::CNT_W'(grma_pkg::ROOT_W - 1))
                begin
                    state_next = grma_pkg::ST_WIN;
                end
                else
                begin
                    cnt_next = grma_pkg::CNT_W'(cnt_reg + 1'b1);
                end
            end
            grma_pkg::ST_WIN:
            begin
                // Replace the oldest magnitude and keep the running sum in step.
                wsum_next           = wsum_reg - grma_pkg::SUM_W'(hist_reg[slot_reg])
                                    + grma_pkg::SUM_W'(root_reg);
                hist_next[slot_reg] = root_reg;
                slot_next           = (slot_reg == grma_pkg::SLOT_W'(grma_pkg::WINDOW_LENGTH - 1))
                                    ? '0 : grma_pkg::SLOT_W'(slot_reg + 1'b1);
                phase_next          = grma_pkg::PH_AVG;
                state_next          = grma_pkg::ST_LOAD;
            end
            grma_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_rate_next  = rate_reg;
                    out_temp_next  = temp_reg;
                    out_speed_next = div_lo_reg[grma_pkg::AUX_LANE];
                    out_valid_next = 1'b1;
                    state_next     = grma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = grma_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= grma_pkg::ST_IDLE;
            phase_reg     <= grma_pkg::PH_SCALE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pct_reg       <= '0;
            for (int i = 0; i < grma_pkg::AXES; i++)
            begin
                rate_reg[i] <= '0;
            end
            for (int i = 0; i < grma_pkg::WINDOW_LENGTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            slot_reg      <= '0;
            wsum_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                pct_reg <= smoothing_percent;
            end
            rate_reg      <= rate_next;
            hist_reg      <= hist_next;
            slot_reg      <= slot_next;
            wsum_reg      <= wsum_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            raw_reg[0]   <= raw_rate_x;
            raw_reg[1]   <= raw_rate_y;
            raw_reg[2]   <= raw_rate_z;
            raw_temp_reg <= raw_temperature;
        end
        scaled_reg    <= scaled_next;
        part_reg      <= part_next;
        temp_reg      <= temp_next;
        sq_reg        <= sq_next;
        div_rem_reg   <= div_rem_next;
        div_lo_reg    <= div_lo_next;
        div_dv_reg    <= div_dv_next;
        rad_reg       <= rad_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        out_rate_reg  <= out_rate_next;
        out_temp_reg  <= out_temp_next;
        out_speed_reg <= out_speed_next;
    end

endmodule

>>> sv/grma_checker.sv
module grma_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [grma_pkg::RATE_W-1:0]  roll_rate,
    input logic signed [grma_pkg::RATE_W-1:0]  pitch_rate,
    input logic signed [grma_pkg::RATE_W-1:0]  yaw_rate,
    input logic signed [grma_pkg::TEMP_W-1:0]  temperature,
    input logic        [grma_pkg::SPEED_W-1:0] average_speed
);

    // Words taken in but not yet delivered.
    logic [1:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= 2'(pend_reg + (in_valid && !in_stall) - (out_valid && !out_stall));
        end
    end

    // A stalled result word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable(roll_rate) && $stable(pitch_rate) && $stable(yaw_rate)
            && $stable(temperature) && $stable(average_speed))
        else $error("stalled result word changed");

    // A result word only appears for a sample that was taken in.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result word without a pending sample");

    // With one word waiting and one in flight, no further sample may enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> in_stall)
        else $error("sample taken while two words are outstanding");

    // Result fields stay inside their physical ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> roll_rate >= -grma_pkg::RATE_LIMIT && roll_rate <= grma_pkg::RATE_LIMIT
            && pitch_rate >= -grma_pkg::RATE_LIMIT && pitch_rate <= grma_pkg::RATE_LIMIT
            && yaw_rate >= -grma_pkg::RATE_LIMIT && yaw_rate <= grma_pkg::RATE_LIMIT
            && temperature >= grma_pkg::TEMP_LOW && temperature <= grma_pkg::TEMP_HIGH
            && average_speed <= grma_pkg::SPEED_MAX)
        else $error("result field out of range");

endmodule

bind gyro_rate_magnitude_averager grma_checker u_grma_checker (.*);

>>> tb/rate_average_checker.sv
`timescale 1ns / 100ps

module rate_average_checker
    import grma_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic signed [RAW_W-1:0]     raw_rate_x,
    input  logic signed [RAW_W-1:0]     raw_rate_y,
    input  logic signed [RAW_W-1:0]     raw_rate_z,
    input  logic signed [RAW_W-1:0]     raw_temperature,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [RATE_W-1:0]    roll_rate,
    input  logic signed [RATE_W-1:0]    pitch_rate,
    input  logic signed [RATE_W-1:0]    yaw_rate,
    input  logic signed [TEMP_W-1:0]    temperature,
    input  logic        [SPEED_W-1:0]   average_speed,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic        [PCT_W-1:0]     smoothing_percent,
    output int                          failures,
    output int                          outstanding
);

    typedef struct packed {
        logic signed [RATE_W-1:0]  roll;
        logic signed [RATE_W-1:0]  pitch;
        logic signed [RATE_W-1:0]  yaw;
        logic signed [TEMP_W-1:0]  temp;
        logic        [SPEED_W-1:0] speed;
    } rate_word_t;

    rate_word_t      expected_words [$];
    longint          roll_filt;
    longint          pitch_filt;
    longint          yaw_filt;
    longint unsigned speed_history [WINDOW_LENGTH];
    int              history_pos;
    longint unsigned speed_total;
    int              percent_kept;
    int              mismatch_count;

    function automatic longint scale_raw(input logic signed [RAW_W-1:0] raw);
        return (longint'(raw) * RATE_MUL) / RATE_DIV;
    endfunction

    function automatic longint smooth_rate(input longint prev, input longint scaled,
                                           input longint c);
        return (prev * c) / PERCENT_FULL + (scaled * (PERCENT_FULL - c)) / PERCENT_FULL;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // Advances the filter and window state by one sample and returns the word it yields.
    function automatic rate_word_t predict_word(input logic signed [RAW_W-1:0] x,
                                                input logic signed [RAW_W-1:0] y,
                                                input logic signed [RAW_W-1:0] z,
                                                input logic signed [RAW_W-1:0] t);
        rate_word_t      w;
        longint          c;
        longint          temp_c;
        longint unsigned mag;
        c = (percent_kept > PERCENT_FULL) ? PERCENT_FULL : percent_kept;
        roll_filt  = smooth_rate(roll_filt,  scale_raw(x), c);
        pitch_filt = smooth_rate(pitch_filt, scale_raw(y), c);
        yaw_filt   = smooth_rate(yaw_filt,   scale_raw(z), c);
        temp_c = (longint'(t) * TEMP_MUL) / TEMP_DIV + TEMP_OFFSET;
        mag = floor_root(roll_filt * roll_filt + pitch_filt * pitch_filt
                         + yaw_filt * yaw_filt);
        speed_total = speed_total - speed_history[history_pos] + mag;
        speed_history[history_pos] = mag;
        history_pos = (history_pos + 1) % WINDOW_LENGTH;
        w.roll  = RATE_W'(roll_filt);
        w.pitch = RATE_W'(pitch_filt);
        w.yaw   = RATE_W'(yaw_filt);
        w.temp  = TEMP_W'(temp_c);
        w.speed = SPEED_W'(speed_total / WINDOW_LENGTH);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rate_word_t want;
        rate_word_t got;
        if (!rst_n)
        begin
            expected_words.delete();
            roll_filt   = 0;
            pitch_filt  = 0;
            yaw_filt    = 0;
            for (int i = 0; i < WINDOW_LENGTH; i++)
                speed_history[i] = 0;
            history_pos    = 0;
            speed_total    = 0;
            percent_kept   = 0;
            mismatch_count = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                percent_kept = smoothing_percent;
            if (in_valid && !in_stall)
                expected_words.push_back(predict_word(raw_rate_x, raw_rate_y,
                                                      raw_rate_z, raw_temperature));
            if (out_valid && !out_stall)
            begin
                got.roll  = roll_rate;
                got.pitch = pitch_rate;
                got.yaw   = yaw_rate;
                got.temp  = temperature;
                got.speed = average_speed;
                if (expected_words.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result word: roll %0d pitch %0d yaw %0d",
                                 got.roll, got.pitch, got.yaw);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want.roll !== got.roll || want.pitch !== got.pitch
                        || want.yaw !== got.yaw || want.temp !== got.temp
                        || want.speed !== got.speed)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display({"mismatch expected: roll %0d pitch %0d yaw %0d",
                                      " temp %0d speed %0d"},
                                     want.roll, want.pitch, want.yaw, want.temp,
                                     want.speed);
                            $display({"         actual:   roll %0d pitch %0d yaw %0d",
                                      " temp %0d speed %0d"},
                                     got.roll, got.pitch, got.yaw, got.temp, got.speed);
                        end
                        mismatch_count++;
                    end
                end
            end
            failures    <= mismatch_count;
            outstanding <= expected_words.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import grma_pkg::*;

    // With the longest sender gaps and receiver stalls, this limit leaves several
    // times the slowest legal run.
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 83;
    // Settling pause that drain_block adds after the last result word has come back.
    localparam int DRAIN_CYCLES    = 120;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic signed [RAW_W-1:0]   raw_rate_x = '0;
    logic signed [RAW_W-1:0]   raw_rate_y = '0;
    logic signed [RAW_W-1:0]   raw_rate_z = '0;
    logic signed [RAW_W-1:0]   raw_temperature = '0;
    logic                      out_stall = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic        [PCT_W-1:0]   smoothing_percent = '0;

    logic                      in_stall;
    logic                      out_valid;
    logic signed [RATE_W-1:0]  roll_rate;
    logic signed [RATE_W-1:0]  pitch_rate;
    logic signed [RATE_W-1:0]  yaw_rate;
    logic signed [TEMP_W-1:0]  temperature;
    logic        [SPEED_W-1:0] average_speed;
    logic                      cfg_ready;

    int failures;
    int outstanding;
    int cycle_count = 0;
    int stall_hold = 0;

    // These switch sender gaps and receiver stalls on and off per phase, so that
    // some stretches run back to back.
    bit idle_on = 1'b1;
    bit stall_on = 1'b1;

    always #10 clk = ~clk;

    gyro_rate_magnitude_averager dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .raw_rate_x        (raw_rate_x),
        .raw_rate_y        (raw_rate_y),
        .raw_rate_z        (raw_rate_z),
        .raw_temperature   (raw_temperature),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .roll_rate         (roll_rate),
        .pitch_rate        (pitch_rate),
        .yaw_rate          (yaw_rate),
        .temperature       (temperature),
        .average_speed     (average_speed),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .smoothing_percent (smoothing_percent)
    );

    // The checker watches all three channels, predicts every result word and
    // compares; the top only makes stimulus and reads back the two counts.
    rate_average_checker result_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .raw_rate_x        (raw_rate_x),
        .raw_rate_y        (raw_rate_y),
        .raw_rate_z        (raw_rate_z),
        .raw_temperature   (raw_temperature),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .roll_rate         (roll_rate),
        .pitch_rate        (pitch_rate),
        .yaw_rate          (yaw_rate),
        .temperature       (temperature),
        .average_speed     (average_speed),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .smoothing_percent (smoothing_percent),
        .failures          (failures),
        .outstanding       (outstanding)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver back-pressure. The stall level is held for a random number of cycles,
    // mostly short, now and then long enough to outlast a whole sample so that the
    // block fills its output register and must hold off the sender.
    always @(posedge clk)
    begin
        if (stall_hold != 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            out_stall  <= stall_on && ($urandom_range(0, 2) == 0);
            stall_hold <= ($urandom_range(0, 14) == 0) ? $urandom_range(20, 150)
                                                       : $urandom_range(0, 3);
        end
    end

    // Gap before the next sender word: mostly none or short, a few long ones.
    function automatic int next_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 120);
    endfunction

    // Raw readings lean toward the rails and toward zero, where the scaling and
    // the square root are most likely to go wrong, and otherwise span the full range.
    function automatic logic signed [RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return RAW_W'(-32768);
            1: return RAW_W'(32767);
            2: return RAW_W'(int'($urandom_range(0, 200)) - 100);
            default: return RAW_W'($urandom());
        endcase
    endfunction

    // Offers one sample word and returns at the edge where it is taken. The valid
    // is only lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_sample(input logic signed [RAW_W-1:0] x,
                               input logic signed [RAW_W-1:0] y,
                               input logic signed [RAW_W-1:0] z,
                               input logic signed [RAW_W-1:0] t);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        raw_rate_x      <= x;
        raw_rate_y      <= y;
        raw_rate_z      <= z;
        raw_temperature <= t;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random_sample();
        send_sample(pick_raw(), pick_raw(), pick_raw(), pick_raw());
    endtask

    // Stops offering samples, waits until every predicted word has come back, then
    // lets the block settle before anything touches the register.
    task automatic drain_block();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_smoothing(input logic [PCT_W-1:0] value);
        cfg_valid         <= 1'b1;
        smoothing_percent <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int settings [PHASES];
        settings = '{100, 127, 0, 50, 1, 101, 99, -1, -1, 0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words right after reset, with the register at its reset value of
        // zero so the scaled rates pass straight through. The first six also show the
        // average over a window that is still filling with zeros, and the later ones
        // take the history slot through its wrap.
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd32767, -16'sd32768, 16'sd0, -16'sd1);
        send_sample(-16'sd1, 16'sd1, -16'sd1, 16'sd1);
        send_sample(16'sd1, -16'sd1, 16'sd1, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        send_sample(16'sd0, 16'sd0, 16'sd32767, 16'sd0);
        send_sample(16'sd0, -16'sd32768, 16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd1, 16'sd1, -16'sd1);
        send_sample(-16'sd2, 16'sd2, -16'sd3, 16'sd3);
        send_sample(16'sd655, -16'sd656, 16'sd13107, -16'sd7000);
        send_sample(-16'sd21845, 16'sd21845, 16'sd10000, 16'sd10000);
        drain_block();

        // Directed words with the register above one hundred: the filtered rates
        // must hold at the values left by the last word while the temperature moves.
        write_smoothing(7'd127);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        drain_block();

        // Random phases, each under one register setting and one idling pattern.
        // A setting of -1 stands for a random value.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            idle_on  = (phase % 3) != 1;
            stall_on = (phase % 4) != 2;
            if (settings[phase] < 0)
                write_smoothing(PCT_W'($urandom_range(0, 127)));
            else
                write_smoothing(PCT_W'(settings[phase]));
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_random_sample();
            drain_block();
        end

        if (failures == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
sv/grma_pkg.sv
sv/gyro_rate_magnitude_averager.sv
sv/grma_checker.sv
tb/rate_average_checker.sv
tb/testbench.sv
